// ===== hw/rtl/sobel_edge_magnitude_core_assert.svh =====
// assertion macros shared by the sobel edge magnitude rtl
// expects aclk and aresetn in the scope of each use
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SEM_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sobel core assertion failed");
`define SEM_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge aclk) prop) \
        else $error("sobel core assertion failed");
`else
`define SEM_ASSERT(name, prop)
`define SEM_ASSERT_ALWAYS(name, prop)
`endif

`endif

// ===== hw/rtl/sem_pkg.sv =====
// types, constants and helpers for the sobel edge magnitude core
// no dependencies
`timescale 1ns / 1ps

package sem_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 12;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 12;
    localparam int SUM_W      = 21;
    localparam int ROOT_BITS  = 8;
    localparam int STEP_W     = $clog2(ROOT_BITS);
    localparam int IDX_W      = 2;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd1247;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd720;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_GRAD,
        ST_SQUARE,
        ST_START,
        ST_ROOT,
        ST_OUT
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/sobel_edge_magnitude_core.sv =====
// top level of the streaming sobel edge magnitude core
// depends on sem_pkg, sem_line_mem, sem_root and the assertion macro header
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_core_assert.svh"

// Streaming 3x3 Sobel edge magnitude over 8-bit grey pixels in raster order,
// with clamp-to-edge borders. Each result is min(255, floor(sqrt(gx^2+gy^2)))
// and comes out one row plus one pixel after its pixel; once a frame is in,
// flush transactions (tuser = 1) drain the rest, one result per flush, and the
// bottom-right result carries tlast. Items are handled one at a time: an item
// that gives no result is either ignored or goes through a line memory
// read-modify-write; one that gives a result also passes the gradient and
// square stages and the square root unit, which resolves one bit per cycle
// unless the sum of squares saturates, and may wait for the output register
// to free up; the first flush of a single-row frame takes two memory passes.
// A finished result waits in the output register while the next item is
// taken. Register writes are taken only between items, hold off the pixel
// channel while pending, and restart the frame when they go to the width
// or height.
module sobel_edge_magnitude_core
    import sem_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PIX_W-1:0]   s_tdata,    // pixel
    input  logic               s_tuser,    // operation
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [PIX_W-1:0]   m_tdata,    // edge_res
    output logic               m_tlast,    // last_of_frame
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]   cfg_data
);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  width_cfg_reg, height_cfg_reg;
    logic [DIM_W-1:0]  w_eff, h_eff;
    logic [COL_W-1:0]  in_col_reg;
    logic [DIM_W-1:0]  in_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [COL_W-1:0]  out_row_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic              flush_reg;
    logic              second_reg;
    logic [PIX_W-1:0]  win_reg [3][3];
    logic signed [GRAD_W-1:0] gx_reg, gy_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              last_reg;
    logic              m_valid_reg;
    logic [PIX_W-1:0]  m_data_reg;
    logic              m_last_reg;

    logic              in_acc, cfg_acc;
    logic              complete, take_item, due;
    logic              col_wrap;
    logic [2*PIX_W-1:0] mem_rdata;
    logic [PIX_W-1:0]  up_pix, low_pix;
    logic              root_start, root_done;
    logic [ROOT_BITS-1:0] root_val;
    logic              out_free;

    logic [1:0]        top_i, bot_i, lft_i, rgt_i;
    logic              last_col, last_row, last_pos;
    logic signed [GRAD_W-1:0] t0, t1, t2, m0, m2, b0, b1, b2;
    logic signed [GRAD_W-1:0] gx_next, gy_next;
    logic signed [2*GRAD_W-1:0] sq_x, sq_y;
    logic [SUM_W-1:0]  sum_next;

    assign w_eff = clamp_dim(width_cfg_reg, DIM_W'(MAX_WIDTH));
    assign h_eff = clamp_dim(height_cfg_reg, DIM_W'(MAX_HEIGHT));

    // register writes only between items, and they go ahead of a waiting pixel
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_acc   = cfg_valid && cfg_ready;

    assign complete  = (in_row_reg >= h_eff);
    // pixels while draining and flushes before the frame is in are dropped
    assign take_item = (s_tuser == OP_FLUSH) ? complete : !complete;
    assign due = (in_row_reg >= DIM_W'(2)) ||
                 ((in_row_reg == DIM_W'(1)) && (in_col_reg != '0));
    assign col_wrap = ({1'b0, in_col_reg} + DIM_W'(1)) >= w_eff;

    assign up_pix  = mem_rdata[2*PIX_W-1:PIX_W];
    assign low_pix = mem_rdata[PIX_W-1:0];

    sem_line_mem u_line_mem (
        .aclk  (aclk),
        .we    (state_reg == ST_SHIFT),
        .waddr (in_col_reg),
        .wdata ({low_pix, pix_reg}),
        .re    (state_reg == ST_READ),
        .raddr (in_col_reg),
        .rdata (mem_rdata)
    );

    // window taps with the border rows and columns clamped
    assign last_col = ({1'b0, out_col_reg} + DIM_W'(1)) >= w_eff;
    assign last_row = ({1'b0, out_row_reg} + DIM_W'(1)) >= h_eff;
    assign last_pos = last_col && last_row;
    assign top_i = (out_row_reg == '0) ? 2'd1 : 2'd0;
    assign bot_i = last_row ? 2'd1 : 2'd2;
    assign lft_i = (out_col_reg == '0) ? 2'd1 : 2'd0;
    assign rgt_i = last_col ? 2'd1 : 2'd2;

    assign t0 = $signed({4'b0, win_reg[top_i][lft_i]});
    assign t1 = $signed({4'b0, win_reg[top_i][1]});
    assign t2 = $signed({4'b0, win_reg[top_i][rgt_i]});
    assign m0 = $signed({4'b0, win_reg[1][lft_i]});
    assign m2 = $signed({4'b0, win_reg[1][rgt_i]});
    assign b0 = $signed({4'b0, win_reg[bot_i][lft_i]});
    assign b1 = $signed({4'b0, win_reg[bot_i][1]});
    assign b2 = $signed({4'b0, win_reg[bot_i][rgt_i]});

    assign gx_next = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
    assign gy_next = (b0 + (b1 <<< 1) + b2) - (t0 + (t1 <<< 1) + t2);

    assign sq_x = gx_reg * gx_reg;
    assign sq_y = gy_reg * gy_reg;
    assign sum_next = SUM_W'($unsigned(sq_x) + $unsigned(sq_y));

    assign root_start = (state_reg == ST_START);
    assign out_free   = !m_valid_reg || m_tready;

    sem_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .sum     (sum_reg),
        .done    (root_done),
        .root    (root_val)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && take_item) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (due) begin
                    state_next = ST_GRAD;
                end else if (flush_reg && !second_reg) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_GRAD: begin
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                state_next = ST_START;
            end
            ST_START: begin
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            flush_reg      <= 1'b0;
            second_reg     <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (cfg_acc) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_cfg_reg <= cfg_data;
            end else if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_cfg_reg <= cfg_data;
            end
            if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        flush_reg  <= (s_tuser == OP_FLUSH);
                        second_reg <= 1'b0;
                        pix_reg    <= (s_tuser == OP_FLUSH) ? '0 : s_tdata;
                    end
                end
                ST_SHIFT: begin
                    win_reg[0][0] <= win_reg[0][1];
                    win_reg[0][1] <= win_reg[0][2];
                    win_reg[0][2] <= up_pix;
                    win_reg[1][0] <= win_reg[1][1];
                    win_reg[1][1] <= win_reg[1][2];
                    win_reg[1][2] <= low_pix;
                    win_reg[2][0] <= win_reg[2][1];
                    win_reg[2][1] <= win_reg[2][2];
                    win_reg[2][2] <= pix_reg;
                    if (col_wrap) begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + DIM_W'(1);
                    end else begin
                        in_col_reg <= in_col_reg + COL_W'(1);
                    end
                    second_reg <= 1'b1;
                end
                ST_GRAD: begin
                    gx_reg   <= gx_next;
                    gy_reg   <= gy_next;
                    last_reg <= last_pos;
                    if (last_pos) begin
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                    end else if (last_col) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + COL_W'(1);
                    end else begin
                        out_col_reg <= out_col_reg + COL_W'(1);
                    end
                end
                ST_SQUARE: begin
                    sum_reg <= sum_next;
                end
                default: begin
                end
            endcase
        end
    end

    // output register, loaded once the root is ready and the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= root_val;
            m_last_reg  <= last_reg;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `SEM_ASSERT(a_shift_after_read, state_reg == ST_SHIFT |-> $past(state_reg) == ST_READ)
    `SEM_ASSERT(a_frame_end_clears,
        (state_reg == ST_GRAD && last_pos && !cfg_acc) |=> (in_row_reg == '0 && in_col_reg == '0))
    `SEM_ASSERT(a_out_col_in_range, {1'b0, out_col_reg} < w_eff || cfg_acc || $past(cfg_acc))

endmodule

// ===== hw/rtl/sem_line_mem.sv =====
// two line stores side by side in one synchronous memory, upper in the high byte
// depends on sem_pkg
`timescale 1ns / 1ps

module sem_line_mem
    import sem_pkg::*;
(
    input  logic                 aclk,
    input  logic                 we,
    input  logic [COL_W-1:0]     waddr,
    input  logic [2*PIX_W-1:0]   wdata,
    input  logic                 re,
    input  logic [COL_W-1:0]     raddr,
    output logic [2*PIX_W-1:0]   rdata
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/sem_root.sv =====
// saturated integer square root, one result bit per cycle
// depends on sem_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_core_assert.svh"

module sem_root
    import sem_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SUM_W-1:0]      sum,
    output logic                  done,
    output logic [ROOT_BITS-1:0]  root
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [ROOT_BITS-1:0]     root_reg;
    logic [2*ROOT_BITS-1:0]   rad_reg;
    logic [ROOT_BITS-1:0]     trial;
    logic [2*ROOT_BITS-1:0]   trial_sq;

    assign trial    = root_reg | (ROOT_BITS'(1) << step_reg);
    assign trial_sq = trial * trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                // anything at or above 2^16 has a root of 256 or more
                if (sum[SUM_W-1:2*ROOT_BITS] != '0) begin
                    root_reg <= '1;
                    done_reg <= 1'b1;
                end else begin
                    root_reg <= '0;
                    rad_reg  <= sum[2*ROOT_BITS-1:0];
                    step_reg <= STEP_W'(ROOT_BITS - 1);
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                if (trial_sq <= rad_reg) begin
                    root_reg <= trial;
                end
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

    `SEM_ASSERT(a_start_when_free, start |-> !busy_reg)
    `SEM_ASSERT(a_done_ends_work, done_reg |-> !busy_reg)
    `SEM_ASSERT(a_done_single, done_reg |=> !done_reg)

endmodule
